>>> hdl/cfs_pkg.sv
// cfs_pkg: types, codes and byte constants of the container format sniffer
// used by the interfaces, the step logic, the top level and the checker

package cfs_pkg;

  typedef enum logic [3:0] {
    PH_START,
    PH_BOM,
    PH_PRELUDE,
    PH_LT,
    PH_BANG,
    PH_DECL,
    PH_COMMENT,
    PH_ROOT,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    V_PENDING,
    V_BINARY,
    V_TEXT,
    V_EMPTY,
    V_OPEN,
    V_NOMATCH
  } verdict_t;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  magic_index;
    logic [2:0]  root_index;
    logic [1:0]  byte_count;
    logic [1:0]  terminator_run;
    logic        binary_alive;
    verdict_t    final_verdict;
  } scan_state_t;

  localparam scan_state_t RESET_STATE = '{
    phase:          PH_START,
    magic_index:    4'd0,
    root_index:     3'd0,
    byte_count:     2'd0,
    terminator_run: 2'd0,
    binary_alive:   1'b1,
    final_verdict:  V_PENDING
  };

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_QUERY = 8'h3F;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] BOM_0    = 8'hEF;
  localparam logic [7:0] BOM_1    = 8'hBB;
  localparam logic [7:0] BOM_2    = 8'hBF;

  localparam logic [2:0] MAGIC_LAST = 3'd7;
  localparam logic [2:0] ROOT_LEN   = 3'd7;

  // binary magic; the root tag is its first seven bytes
  function automatic logic [7:0] magic_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h3C;
      3'd1:    c = 8'h72;
      3'd2:    c = 8'h6F;
      3'd3:    c = 8'h62;
      3'd4:    c = 8'h6C;
      3'd5:    c = 8'h6F;
      3'd6:    c = 8'h78;
      default: c = 8'h21;
    endcase
    return c;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b inside {8'd32, [8'd9:8'd13]});
  endfunction

endpackage

>>> hdl/cfs_if.sv
// cfs_in_if and cfs_out_if: valid/ready channels of the sniffer
// depends on cfs_pkg for the verdict type

interface cfs_in_if;
  logic       valid;
  logic       ready;
  logic       has_byte;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, has_byte, byte_value, last_byte, input ready);
  modport sink   (input valid, has_byte, byte_value, last_byte, output ready);
endinterface

interface cfs_out_if;
  logic                valid;
  logic                ready;
  cfs_pkg::verdict_t   verdict;
  logic                stream_done;

  modport source (output valid, verdict, stream_done, input ready);
  modport sink   (input valid, verdict, stream_done, output ready);
endinterface

>>> hdl/container_format_sniffer_top.sv
// container_format_sniffer_top: byte-stream container format sniffer
// depends on cfs_pkg, cfs_in_if, cfs_out_if and cfs_step
// result: a byte's result is in the output register in the cycle after its transfer
// throughput: one byte per cycle while the result does not stall; a new byte is taken while the result is taken
// the result register holds one item, so ready drops only while it stalls or in reset
// reset: synchronous, clears the scanner state to start of stream and the output valid

module container_format_sniffer_top (
  input  logic             clk,
  input  logic             rst,
  cfs_in_if.sink           stream,
  cfs_out_if.source        report
);

  cfs_pkg::scan_state_t state;
  cfs_pkg::scan_state_t state_next;
  cfs_pkg::verdict_t    step_verdict;
  cfs_pkg::verdict_t    out_verdict;
  logic                 out_done;
  logic                 out_valid;
  logic                 accept;

  cfs_step u_step (
    .cur        (state),
    .has_byte   (stream.has_byte),
    .byte_value (stream.byte_value),
    .last_byte  (stream.last_byte),
    .nxt        (state_next),
    .verdict    (step_verdict)
  );

  assign stream.ready = !rst && (!out_valid || report.ready);
  assign accept       = stream.valid && stream.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cfs_pkg::RESET_STATE;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (report.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_verdict <= step_verdict;
      out_done    <= stream.last_byte;
    end
  end

  assign report.valid       = out_valid;
  assign report.verdict     = out_verdict;
  assign report.stream_done = out_done;

endmodule

>>> hdl/cfs_step.sv
// cfs_step: next scanner state and verdict for one input byte
// depends on cfs_pkg

module cfs_step (
  input  cfs_pkg::scan_state_t cur,
  input  logic                 has_byte,
  input  logic [7:0]           byte_value,
  input  logic                 last_byte,
  output cfs_pkg::scan_state_t nxt,
  output cfs_pkg::verdict_t    verdict
);

  cfs_pkg::scan_state_t upd;
  logic                 bin_hit;
  cfs_pkg::verdict_t    end_verdict;

  always_comb begin
    upd     = cur;
    bin_hit = 1'b0;
    if (has_byte && cur.phase != cfs_pkg::PH_DONE) begin
      if (cur.binary_alive && !cur.magic_index[3]) begin
        if (byte_value == cfs_pkg::magic_char(cur.magic_index[2:0])) begin
          upd.magic_index = cur.magic_index + 4'd1;
          bin_hit         = (cur.magic_index[2:0] == cfs_pkg::MAGIC_LAST);
        end else begin
          upd.binary_alive = 1'b0;
        end
      end

      case (cur.phase)
        cfs_pkg::PH_START, cfs_pkg::PH_PRELUDE: begin
          if (cur.phase == cfs_pkg::PH_START && byte_value == cfs_pkg::BOM_0) begin
            upd.phase      = cfs_pkg::PH_BOM;
            upd.byte_count = 2'd1;
          end else if (cfs_pkg::is_space(byte_value)) begin
            upd.phase = cfs_pkg::PH_PRELUDE;
          end else if (byte_value == cfs_pkg::CH_LT) begin
            upd.phase = cfs_pkg::PH_LT;
          end else begin
            upd.phase         = cfs_pkg::PH_DONE;
            upd.final_verdict = cfs_pkg::V_NOMATCH;
          end
        end
        cfs_pkg::PH_BOM: begin
          if (cur.byte_count == 2'd1 && byte_value == cfs_pkg::BOM_1) begin
            upd.byte_count = 2'd2;
          end else if (cur.byte_count == 2'd2 && byte_value == cfs_pkg::BOM_2) begin
            upd.byte_count = 2'd0;
            upd.phase      = cfs_pkg::PH_PRELUDE;
          end else begin
            upd.phase         = cfs_pkg::PH_DONE;
            upd.final_verdict = cfs_pkg::V_NOMATCH;
          end
        end
        cfs_pkg::PH_LT: begin
          if (byte_value == cfs_pkg::CH_QUERY) begin
            upd.phase          = cfs_pkg::PH_DECL;
            upd.terminator_run = 2'd0;
          end else if (byte_value == cfs_pkg::CH_BANG) begin
            upd.phase      = cfs_pkg::PH_BANG;
            upd.byte_count = 2'd0;
          end else if (byte_value == cfs_pkg::CH_R) begin
            upd.phase      = cfs_pkg::PH_ROOT;
            upd.root_index = 3'd2;
          end else begin
            upd.phase         = cfs_pkg::PH_DONE;
            upd.final_verdict = cfs_pkg::V_NOMATCH;
          end
        end
        cfs_pkg::PH_BANG: begin
          if (byte_value != cfs_pkg::CH_DASH) begin
            upd.phase         = cfs_pkg::PH_DONE;
            upd.final_verdict = cfs_pkg::V_NOMATCH;
          end else if (cur.byte_count == 2'd0) begin
            upd.byte_count = 2'd1;
          end else begin
            upd.byte_count     = 2'd0;
            upd.phase          = cfs_pkg::PH_COMMENT;
            upd.terminator_run = 2'd0;
          end
        end
        cfs_pkg::PH_DECL: begin
          if (cur.terminator_run == 2'd1 && byte_value == cfs_pkg::CH_GT) begin
            upd.terminator_run = 2'd0;
            upd.phase          = cfs_pkg::PH_PRELUDE;
          end else begin
            upd.terminator_run = (byte_value == cfs_pkg::CH_QUERY) ? 2'd1 : 2'd0;
          end
        end
        cfs_pkg::PH_COMMENT: begin
          if (cur.terminator_run[1] && byte_value == cfs_pkg::CH_GT) begin
            upd.terminator_run = 2'd0;
            upd.phase          = cfs_pkg::PH_PRELUDE;
          end else if (byte_value == cfs_pkg::CH_DASH) begin
            upd.terminator_run = cur.terminator_run[1] ? 2'd2 : cur.terminator_run + 2'd1;
          end else begin
            upd.terminator_run = 2'd0;
          end
        end
        cfs_pkg::PH_ROOT: begin
          if (cur.root_index != cfs_pkg::ROOT_LEN) begin
            if (byte_value == cfs_pkg::magic_char(cur.root_index)) begin
              upd.root_index = cur.root_index + 3'd1;
            end else begin
              upd.phase         = cfs_pkg::PH_DONE;
              upd.final_verdict = cfs_pkg::V_NOMATCH;
            end
          end else begin
            upd.phase = cfs_pkg::PH_DONE;
            if (cfs_pkg::is_space(byte_value) || byte_value == cfs_pkg::CH_GT ||
                byte_value == cfs_pkg::CH_SLASH) begin
              upd.final_verdict = cfs_pkg::V_TEXT;
            end else begin
              upd.final_verdict = cfs_pkg::V_NOMATCH;
            end
          end
        end
        default: begin
        end
      endcase

      if (bin_hit) begin
        upd.phase         = cfs_pkg::PH_DONE;
        upd.final_verdict = cfs_pkg::V_BINARY;
      end
    end
  end

  always_comb begin
    case (upd.phase)
      cfs_pkg::PH_DONE:    end_verdict = upd.final_verdict;
      cfs_pkg::PH_START:   end_verdict = cfs_pkg::V_EMPTY;
      cfs_pkg::PH_DECL,
      cfs_pkg::PH_COMMENT: end_verdict = cfs_pkg::V_OPEN;
      cfs_pkg::PH_ROOT: begin
        end_verdict = (upd.root_index == cfs_pkg::ROOT_LEN) ? cfs_pkg::V_TEXT
                                                            : cfs_pkg::V_NOMATCH;
      end
      default:             end_verdict = cfs_pkg::V_NOMATCH;
    endcase
  end

  // rearm after the final item of a stream
  assign nxt     = last_byte ? cfs_pkg::RESET_STATE : upd;
  assign verdict = last_byte ? end_verdict : upd.final_verdict;

endmodule

>>> hdl/cfs_checker.sv
// cfs_checker: port-level assertions for the sniffer top level
// depends on cfs_pkg; bound to container_format_sniffer_top below

module cfs_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] verdict,
  input logic       stream_done
);

  // a final result always carries a settled verdict
  a_done_not_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid && stream_done |-> verdict != cfs_pkg::V_PENDING)
    else $error("stream end reported with pending verdict");

  a_verdict_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> verdict <= cfs_pkg::V_NOMATCH)
    else $error("verdict code out of range");

  // every input transfer yields a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("input transfer without result");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(verdict) && $stable(stream_done))
    else $error("stalled result changed");

endmodule

bind container_format_sniffer_top cfs_checker u_cfs_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (stream.valid),
  .in_ready    (stream.ready),
  .out_valid   (report.valid),
  .out_ready   (report.ready),
  .verdict     (report.verdict),
  .stream_done (report.stream_done)
);
